// File: rtl/ndefp_pkg.sv
// shared types and constants of the ndef record header parser
`default_nettype none

package ndefp_pkg;

	// long payload length form, big-endian byte count
	localparam int LONG_LEN_BYTES = 4;
	localparam int LEN_IDX_W      = 2;
	localparam logic [LEN_IDX_W-1:0] LEN_IDX_LAST = LEN_IDX_W'(LONG_LEN_BYTES - 1);

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// header flag bit positions
	localparam int FLAG_MB = 7;
	localparam int FLAG_ME = 6;
	localparam int FLAG_SR = 4;
	localparam int FLAG_IL = 3;

	// stream widths
	localparam int IN_TDATA_W  = 8;
	localparam int IN_TUSER_W  = 1;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_TUSER_W = 4;

	// parse phase, also the section tag of a byte
	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_TYPE_LEN = 3'd1,
		PH_PAY_LEN  = 3'd2,
		PH_ID_LEN   = 3'd3,
		PH_TYPE     = 3'd4,
		PH_ID       = 3'd5,
		PH_PAYLOAD  = 3'd6
	} phase_t;

	// classified input byte
	typedef struct packed {
		logic [7:0] data;
		logic       restart;
		logic       has_mark;
	} item_t;

	// queue status toward its neighbors
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// one result item
	typedef struct packed {
		logic [7:0]  byte_out;
		logic [2:0]  section;
		logic        record_done;
		logic        status;
		logic [7:0]  header_flags;
		logic [7:0]  type_length;
		logic [7:0]  id_length;
		logic [31:0] payload_length;
		logic [32:0] record_len;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/ndefp_front.sv
// front stage: accepts stream bytes and marks header candidates
`default_nettype none

module ndefp_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [ndefp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	input  wire logic [ndefp_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	input  wire ndefp_pkg::fifo_stat_t             q_stat,
	output logic                                   q_push,
	output ndefp_pkg::item_t                       q_item
);
	import ndefp_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	logic  accept;

	// hand the staged byte to the queue when it has room
	assign q_push        = valid_s1 && !q_stat.full;
	assign s_axis_tready = !valid_s1 || !q_stat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign q_item        = item_s1;

	// stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// capture and classify the byte
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data     <= s_axis_tdata[7:0];
			item_s1.restart  <= s_axis_tuser[0];
			item_s1.has_mark <= s_axis_tdata[FLAG_MB] | s_axis_tdata[FLAG_ME];
		end
	end

endmodule

`default_nettype wire

// File: rtl/ndefp_fifo.sv
// short queue of classified bytes between front and back
`default_nettype none

module ndefp_fifo #(
	parameter int DEPTH = ndefp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ndefp_pkg::item_t  push_item,
	input  wire logic              pop,
	output ndefp_pkg::item_t       pop_item,
	output ndefp_pkg::fifo_stat_t  stat
);
	import ndefp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	item_t            entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign pop_item   = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ndefp_back.sv
// back stage: record parser state machine and result register
`default_nettype none

module ndefp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ndefp_pkg::item_t  q_item,
	input  wire ndefp_pkg::fifo_stat_t q_stat,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output ndefp_pkg::result_t     out_result
);
	import ndefp_pkg::*;

	phase_t               phase_q, phase_d;
	logic [7:0]           hdr_q, hdr_d;
	logic [7:0]           tl_q, tl_d;
	logic [7:0]           id_q, id_d;
	logic [31:0]          pl_q, pl_d;
	logic [LEN_IDX_W-1:0] idx_q, idx_d;
	logic [31:0]          rem_q, rem_d;
	logic [32:0]          cnt_q, cnt_d;

	logic                 out_valid_q;
	result_t              result_q;

	logic                 hdr_byte;
	logic                 pay_end;
	logic                 adv_req;
	logic [2:0]           adv_from;
	logic [31:0]          rem_dec;
	logic                 done;
	logic                 not_found;
	logic [2:0]           section;
	logic [7:0]           b;

	// take a byte when the result register is free or being drained
	assign q_pop      = !q_stat.empty && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;
	assign out_result = result_q;
	assign b          = q_item.data;

	// next parse state for the byte at the queue head
	always_comb begin
		phase_d   = phase_q;
		hdr_d     = hdr_q;
		tl_d      = tl_q;
		id_d      = id_q;
		pl_d      = pl_q;
		idx_d     = idx_q;
		rem_d     = rem_q;
		cnt_d     = cnt_q;
		pay_end   = 1'b0;
		adv_req   = 1'b0;
		adv_from  = PH_TYPE;
		rem_dec   = rem_q;
		done      = 1'b0;
		not_found = 1'b0;
		section   = PH_HEADER;
		hdr_byte  = q_item.restart || (phase_q == PH_HEADER) || (phase_q > PH_PAYLOAD);

		if (hdr_byte) begin
			if (!q_item.has_mark) begin
				not_found = 1'b1;
				phase_d   = PH_HEADER;
				cnt_d     = '0;
			end else begin
				hdr_d   = b;
				tl_d    = '0;
				id_d    = '0;
				pl_d    = '0;
				idx_d   = '0;
				rem_d   = '0;
				cnt_d   = 33'd1;
				phase_d = PH_TYPE_LEN;
			end
		end else begin
			section = phase_q;
			cnt_d   = cnt_q + 33'd1;
			unique case (phase_q)
				PH_TYPE_LEN: begin
					tl_d    = b;
					idx_d   = '0;
					pl_d    = '0;
					phase_d = PH_PAY_LEN;
				end
				PH_PAY_LEN: begin
					if (hdr_q[FLAG_SR]) begin
						pl_d    = {24'd0, b};
						pay_end = 1'b1;
					end else begin
						pl_d = {pl_q[23:0], b};
						if (idx_q >= LEN_IDX_LAST) begin
							idx_d   = '0;
							pay_end = 1'b1;
						end else begin
							idx_d = idx_q + 1'b1;
						end
					end
					if (pay_end) begin
						if (hdr_q[FLAG_IL]) begin
							phase_d = PH_ID_LEN;
						end else begin
							id_d     = '0;
							adv_req  = 1'b1;
							adv_from = PH_TYPE;
						end
					end
				end
				PH_ID_LEN: begin
					id_d     = b;
					adv_req  = 1'b1;
					adv_from = PH_TYPE;
				end
				PH_TYPE, PH_ID, PH_PAYLOAD: begin
					if (rem_q != '0) begin
						rem_dec = rem_q - 32'd1;
					end
					rem_d = rem_dec;
					if (rem_dec == '0) begin
						adv_req  = 1'b1;
						adv_from = phase_q + 3'd1;
					end
				end
				default: begin
					phase_d = PH_HEADER;
				end
			endcase
		end

		// enter the first non-empty body section, else close the record
		if (adv_req) begin
			priority if (adv_from <= PH_TYPE && tl_d != '0) begin
				phase_d = PH_TYPE;
				rem_d   = {24'd0, tl_d};
			end else if (adv_from <= PH_ID && id_d != '0) begin
				phase_d = PH_ID;
				rem_d   = {24'd0, id_d};
			end else if (adv_from <= PH_PAYLOAD && pl_d != '0) begin
				phase_d = PH_PAYLOAD;
				rem_d   = pl_d;
			end else begin
				phase_d = PH_HEADER;
				rem_d   = '0;
				done    = 1'b1;
			end
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_q   <= '0;
			tl_q    <= '0;
			id_q    <= '0;
			pl_q    <= '0;
			idx_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else if (q_pop) begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			tl_q    <= tl_d;
			id_q    <= id_d;
			pl_q    <= pl_d;
			idx_q   <= idx_d;
			rem_q   <= rem_d;
			cnt_q   <= cnt_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			result_q.byte_out       <= b;
			result_q.section        <= section;
			result_q.record_done    <= done;
			result_q.status         <= not_found;
			result_q.header_flags   <= hdr_d;
			result_q.type_length    <= tl_d;
			result_q.id_length      <= id_d;
			result_q.payload_length <= pl_d;
			result_q.record_len     <= not_found ? 33'd0 : cnt_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ndef_record_header_parser.sv
// ndef record header parser: an input byte passes the front stage register, the queue and the result register
// throughput one byte per cycle while the output is not stalled, set by the parse step in the back stage
// a queue of QUEUE_DEPTH bytes lets the input side run on while the output stalls
// reset (arst_n low) empties the pipeline and queue and returns the parser to header
// a byte without the MB or ME flag in header position reports status not found
`default_nettype none

module ndef_record_header_parser #(
	parameter int QUEUE_DEPTH = ndefp_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	// data_byte
	input  wire logic [ndefp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// restart
	input  wire logic [ndefp_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// byte_out, header_flags, type_length, id_length, payload_length,
	// record_len, zero pad
	output logic [ndefp_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
	// section, status
	output logic [ndefp_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,
	// record_done
	output logic                                    m_axis_tlast
);
	import ndefp_pkg::*;

	item_t      q_in_item;
	item_t      q_out_item;
	logic       q_push;
	logic       q_pop;
	fifo_stat_t q_stat;
	result_t    res;

	ndefp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.q_stat       (q_stat),
		.q_push       (q_push),
		.q_item       (q_in_item)
	);

	ndefp_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_in_item),
		.pop      (q_pop),
		.pop_item (q_out_item),
		.stat     (q_stat)
	);

	ndefp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (q_out_item),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_result(res)
	);

	// pack the result onto the output stream
	assign m_axis_tdata = {7'd0, res.record_len, res.payload_length, res.id_length,
		res.type_length, res.header_flags, res.byte_out};
	assign m_axis_tuser = {res.status, res.section};
	assign m_axis_tlast = res.record_done;

	// queue never written when full
	assert property (@(posedge clk) disable iff (!arst_n) !(q_push && q_stat.full))
		else $error("queue overflow");

	// queue never read when empty
	assert property (@(posedge clk) disable iff (!arst_n) !(q_pop && q_stat.empty))
		else $error("queue underflow");

	// a not found header never closes a record and carries no length
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.status) |-> (!res.record_done && res.record_len == '0))
		else $error("not found result with record data");

	// a record closes only on a body or length byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && res.record_done) |-> (res.section != PH_HEADER
			&& res.section != PH_TYPE_LEN && res.record_len > 33'd2))
		else $error("record closed on header or type length byte");

endmodule

`default_nettype wire
